FILE: rtl/lru_block_buffer_directory_core_defines.svh
// Assertion macros shared by the buffer directory RTL.
// Included by modules that carry concurrent checks; depends on nothing.
`ifndef LRU_BLOCK_BUFFER_DIRECTORY_CORE_DEFINES_SVH
`define LRU_BLOCK_BUFFER_DIRECTORY_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Plain property, checked outside reset
`define LBBD_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("buffer directory check failed");
// Same-cycle implication
`define LBBD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("buffer directory implication failed");
// Next-cycle implication
`define LBBD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("buffer directory next-cycle check failed");
`else
`define LBBD_ASSERT(label, clk, rst_n, prop)
`define LBBD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LBBD_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/lbbd_pkg.sv
// Shared constants and types of the LRU block buffer directory.
// No dependencies; used by lbbd_lookup and the top level.
`timescale 1ns / 1ps

package lbbd_pkg;

    // Fixed field widths
    localparam int HANDLE_W = 10;
    localparam int OFFSET_W = 32;
    localparam int SLOT_W   = 4;
    localparam int COUNT_W  = 5;

    // Item kinds
    localparam logic KIND_ACCESS = 1'b0;
    localparam logic KIND_CLOSE  = 1'b1;

    // Lookup status toward the update logic
    typedef struct packed {
        logic hit;
        logic free;
    } lbbd_status_t;

endpackage

FILE: rtl/lbbd_lookup.sv
// Tag match and slot selection of the buffer directory.
// Depends on lbbd_pkg for field widths and the status type.
`timescale 1ns / 1ps

module lbbd_lookup #(
    parameter int SLOTS  = 16,
    parameter int BLK_W  = 20,
    parameter int RANK_W = 4,
    parameter int IDX_W  = 4
) (
    input  logic [SLOTS-1:0]              valid_vec,
    input  logic [lbbd_pkg::HANDLE_W-1:0] handle_arr [SLOTS],
    input  logic [BLK_W-1:0]              block_arr  [SLOTS],
    input  logic [RANK_W-1:0]             rank_arr   [SLOTS],
    input  logic [lbbd_pkg::HANDLE_W-1:0] req_handle,
    input  logic [BLK_W-1:0]              req_block,
    output lbbd_pkg::lbbd_status_t        status,
    output logic [IDX_W-1:0]              hit_idx,
    output logic [RANK_W-1:0]             hit_rank,
    output logic [IDX_W-1:0]              free_idx,
    output logic [IDX_W-1:0]              lru_idx,
    output logic [lbbd_pkg::HANDLE_W-1:0] victim_handle,
    output logic [BLK_W-1:0]              victim_block,
    output logic [SLOTS-1:0]              gone_vec,
    output logic [lbbd_pkg::COUNT_W-1:0]  close_count
);

    localparam int CW = lbbd_pkg::COUNT_W;
    localparam logic [RANK_W-1:0] LRU_RANK = RANK_W'(SLOTS - 1);

    logic [SLOTS-1:0] hit_vec;
    logic [SLOTS-1:0] lru_vec;

    // Compare every slot tag against the request
    always_comb
    begin
        for (int j = 0; j < SLOTS; j++)
        begin
            gone_vec[j] = valid_vec[j] && (handle_arr[j] == req_handle);
            hit_vec[j]  = gone_vec[j] && (block_arr[j] == req_block);
            lru_vec[j]  = valid_vec[j] && (rank_arr[j] == LRU_RANK);
        end
    end

    // Pick the lowest matching, free and least recent slots
    always_comb
    begin
        hit_idx       = '0;
        hit_rank      = '0;
        free_idx      = '0;
        lru_idx       = '0;
        victim_handle = '0;
        victim_block  = '0;
        for (int j = SLOTS - 1; j >= 0; j--)
        begin
            if (hit_vec[j])
            begin
                hit_idx  = IDX_W'(j);
                hit_rank = rank_arr[j];
            end
            if (!valid_vec[j])
            begin
                free_idx = IDX_W'(j);
            end
            if (lru_vec[j])
            begin
                lru_idx       = IDX_W'(j);
                victim_handle = handle_arr[j];
                victim_block  = block_arr[j];
            end
        end
        status.hit  = |hit_vec;
        status.free = ~&valid_vec;
    end

    // Count slots that a close would free
    always_comb
    begin
        close_count = '0;
        for (int j = 0; j < SLOTS; j++)
        begin
            close_count = close_count + CW'(gone_vec[j]);
        end
    end

endmodule

FILE: rtl/lru_block_buffer_directory_core.sv
// Fully associative buffer directory with least-recently-used replacement.
// One item is accepted per clock cycle unless stalled, and each item passes through
// the input register and then the result register. The tag compare across all slots,
// the slot choice and the recency update are done in the cycle the item sits in the
// input register, and the result register captures them at the next edge. A result
// held by the receiver keeps the item in the input register and stalls the input.
// The rate is set by that compare and update over the slot tag array. An access hits
// and becomes most recent, or takes the lowest free slot, or evicts the least recent
// slot with write-back. A close frees every slot of its handle without write-back.
// There is no clearing pass: the slot valid bits reset at once.
`timescale 1ns / 1ps
`include "lru_block_buffer_directory_core_defines.svh"

module lru_block_buffer_directory_core #(
    parameter int SLOTS       = 16,
    parameter int BLOCK_BYTES = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          kind,
    input  logic [lbbd_pkg::HANDLE_W-1:0] file_handle,
    input  logic [lbbd_pkg::OFFSET_W-1:0] byte_offset,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          hit,
    output logic [lbbd_pkg::SLOT_W-1:0]   slot,
    output logic                          fetch,
    output logic [lbbd_pkg::OFFSET_W-1:0] block_base,
    output logic                          write_back,
    output logic [lbbd_pkg::HANDLE_W-1:0] victim_handle,
    output logic [lbbd_pkg::OFFSET_W-1:0] victim_base,
    output logic [lbbd_pkg::COUNT_W-1:0]  closed_count
);

    localparam int HW        = lbbd_pkg::HANDLE_W;
    localparam int OW        = lbbd_pkg::OFFSET_W;
    localparam int SW        = lbbd_pkg::SLOT_W;
    localparam int CW        = lbbd_pkg::COUNT_W;
    localparam int OFF_SHIFT = $clog2(BLOCK_BYTES);
    localparam int BLK_W     = OW - OFF_SHIFT;
    localparam int RANK_W    = $clog2(SLOTS);
    localparam int IDX_W     = $clog2(SLOTS);

    // Input register
    logic            in_valid_reg;
    logic            in_kind_reg;
    logic [HW-1:0]   in_handle_reg;
    logic [OW-1:0]   in_offset_reg;

    // Directory state
    logic [SLOTS-1:0]  valid_reg, valid_next;
    logic [HW-1:0]     handle_reg [SLOTS];
    logic [HW-1:0]     handle_next [SLOTS];
    logic [BLK_W-1:0]  block_reg [SLOTS];
    logic [BLK_W-1:0]  block_next [SLOTS];
    logic [RANK_W-1:0] rank_reg [SLOTS];
    logic [RANK_W-1:0] rank_next [SLOTS];

    // Result register
    logic            out_valid_reg;
    logic            hit_reg, hit_next;
    logic [SW-1:0]   slot_reg, slot_next;
    logic            fetch_reg, fetch_next;
    logic [OW-1:0]   base_reg, base_next;
    logic            wb_reg, wb_next;
    logic [HW-1:0]   vh_reg, vh_next;
    logic [OW-1:0]   vb_reg, vb_next;
    logic [CW-1:0]   count_reg, count_next;

    // Lookup results
    lbbd_pkg::lbbd_status_t status;
    logic [IDX_W-1:0]  hit_idx;
    logic [RANK_W-1:0] hit_rank;
    logic [IDX_W-1:0]  free_idx;
    logic [IDX_W-1:0]  lru_idx;
    logic [HW-1:0]     lu_victim_handle;
    logic [BLK_W-1:0]  lu_victim_block;
    logic [SLOTS-1:0]  gone_vec;
    logic [CW-1:0]     close_count;

    logic              fire;
    logic              is_close;
    logic              evict;
    logic [BLK_W-1:0]  req_block;
    logic [IDX_W-1:0]  sel_idx;
    logic [IDX_W+SW-1:0] sel_wide;
    logic [RANK_W-1:0] below_cnt [SLOTS];

    // Handshake: process when the result register is free or draining
    assign fire     = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || fire;
    assign is_close = (in_kind_reg == lbbd_pkg::KIND_CLOSE);
    assign req_block = in_offset_reg[OW-1:OFF_SHIFT];

    // Hold the accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_kind_reg   <= kind;
            in_handle_reg <= file_handle;
            in_offset_reg <= byte_offset;
        end
    end

    lbbd_lookup #(
        .SLOTS  (SLOTS),
        .BLK_W  (BLK_W),
        .RANK_W (RANK_W),
        .IDX_W  (IDX_W)
    ) u_lookup (
        .valid_vec     (valid_reg),
        .handle_arr    (handle_reg),
        .block_arr     (block_reg),
        .rank_arr      (rank_reg),
        .req_handle    (in_handle_reg),
        .req_block     (req_block),
        .status        (status),
        .hit_idx       (hit_idx),
        .hit_rank      (hit_rank),
        .free_idx      (free_idx),
        .lru_idx       (lru_idx),
        .victim_handle (lu_victim_handle),
        .victim_block  (lu_victim_block),
        .gone_vec      (gone_vec),
        .close_count   (close_count)
    );

    // Choose the slot that receives the access
    assign evict    = !status.hit && !status.free;
    assign sel_idx  = status.hit ? hit_idx : (status.free ? free_idx : lru_idx);
    assign sel_wide = {{SW{1'b0}}, sel_idx};

    // Count freed slots more recent than each survivor of a close
    always_comb
    begin
        for (int j = 0; j < SLOTS; j++)
        begin
            below_cnt[j] = '0;
            for (int k = 0; k < SLOTS; k++)
            begin
                if (gone_vec[k] && (rank_reg[k] < rank_reg[j]))
                begin
                    below_cnt[j] = below_cnt[j] + RANK_W'(1);
                end
            end
        end
    end

    // Update tags, valid bits and recency ranks
    always_comb
    begin
        valid_next  = valid_reg;
        handle_next = handle_reg;
        block_next  = block_reg;
        rank_next   = rank_reg;
        if (fire)
        begin
            if (is_close)
            begin
                for (int j = 0; j < SLOTS; j++)
                begin
                    if (valid_reg[j] && !gone_vec[j])
                    begin
                        rank_next[j] = rank_reg[j] - below_cnt[j];
                    end
                end
                valid_next = valid_reg & ~gone_vec;
            end
            else
            begin
                for (int j = 0; j < SLOTS; j++)
                begin
                    if (IDX_W'(j) == sel_idx)
                    begin
                        valid_next[j] = 1'b1;
                        rank_next[j]  = '0;
                        if (!status.hit)
                        begin
                            handle_next[j] = in_handle_reg;
                            block_next[j]  = req_block;
                        end
                    end
                    else if (valid_reg[j] && (!status.hit || (rank_reg[j] < hit_rank)))
                    begin
                        // age the slots that were more recent than the chosen one
                        rank_next[j] = rank_reg[j] + RANK_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        handle_reg <= handle_next;
        block_reg  <= block_next;
        rank_reg   <= rank_next;
    end

    // Form the result item
    always_comb
    begin
        hit_next   = 1'b0;
        slot_next  = '0;
        fetch_next = 1'b0;
        base_next  = '0;
        wb_next    = 1'b0;
        vh_next    = '0;
        vb_next    = '0;
        count_next = '0;
        if (is_close)
        begin
            count_next = close_count;
        end
        else
        begin
            hit_next   = status.hit;
            slot_next  = sel_wide[SW-1:0];
            fetch_next = !status.hit;
            base_next  = {req_block, {OFF_SHIFT{1'b0}}};
            wb_next    = evict;
            if (evict)
            begin
                vh_next = lu_victim_handle;
                vb_next = {lu_victim_block, {OFF_SHIFT{1'b0}}};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            hit_reg   <= hit_next;
            slot_reg  <= slot_next;
            fetch_reg <= fetch_next;
            base_reg  <= base_next;
            wb_reg    <= wb_next;
            vh_reg    <= vh_next;
            vb_reg    <= vb_next;
            count_reg <= count_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign hit           = hit_reg;
    assign slot          = slot_reg;
    assign fetch         = fetch_reg;
    assign block_base    = base_reg;
    assign write_back    = wb_reg;
    assign victim_handle = vh_reg;
    assign victim_base   = vb_reg;
    assign closed_count  = count_reg;

    // A full directory miss must report a write-back
    `LBBD_ASSERT_NXT(a_evict_reports_wb, clk, rst_n, fire && !is_close && evict, out_valid && write_back)
    // An access never frees a slot
    `LBBD_ASSERT_NXT(a_access_keeps_valid, clk, rst_n, fire && !is_close, (valid_reg & $past(valid_reg)) == $past(valid_reg))
    // A close frees every slot of its handle
    `LBBD_ASSERT_NXT(a_close_frees, clk, rst_n, fire && is_close, (valid_reg & $past(gone_vec)) == '0)
    // A hit neither fetches nor writes back
    `LBBD_ASSERT_IMP(a_hit_no_fetch, clk, rst_n, out_valid_reg && hit_reg, !fetch_reg && !wb_reg)

endmodule
